// ===== rtl/pccv_pkg.sv =====
// Shared types, constants and helpers for the PLL clock configuration validator.
package pccv_pkg;

   // field widths
   localparam int CLK_SRC_W  = 2;
   localparam int CMD_W      = 2;
   localparam int SEL_W      = 2;
   localparam int MULT_W     = 15;
   localparam int DIV_W      = 8;
   localparam int FREQ_W     = 30;
   localparam int FIN_W      = 24;
   localparam int MULT_P1_W  = MULT_W + 1;
   localparam int PROD_W     = 39;
   localparam int DIVIDEND_W = 40;
   localparam int DIVISOR_W  = DIV_W + 1;
   localparam int CNT_W      = 6;

   // command codes
   localparam logic [CMD_W-1:0] CMD_DEC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INC   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_APPLY = 2'd2;

   // field selectors
   localparam logic [SEL_W-1:0] SEL_MULT    = 2'd0;
   localparam logic [SEL_W-1:0] SEL_PREDIV  = 2'd1;
   localparam logic [SEL_W-1:0] SEL_CPU_DIV = 2'd2;

   // clock source codes
   localparam logic [CLK_SRC_W-1:0] SRC_4MHZ    = 2'd0;
   localparam logic [CLK_SRC_W-1:0] SRC_12MHZ   = 2'd1;
   localparam logic [CLK_SRC_W-1:0] SRC_32KHZ   = 2'd2;
   localparam logic [CLK_SRC_W-1:0] SRC_INVALID = 2'd3;

   // saturation limits
   localparam logic [MULT_W-1:0] MULT_MAX = '1;
   localparam logic [DIV_W-1:0]  DIV_MAX  = '1;

   // frequency windows
   localparam logic [DIVIDEND_W-1:0] FCCO_LO = 40'd275000000;
   localparam logic [DIVIDEND_W-1:0] FCCO_HI = 40'd550000000;
   localparam logic [FREQ_W-1:0]     CCLK_LO = 30'd10000000;
   localparam logic [FREQ_W-1:0]     CCLK_HI = 30'd100000000;

   // divider request and response
   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   // frequency calculation request and response
   typedef struct packed {
      logic              start;
      logic [MULT_W-1:0] mult;
      logic [DIV_W-1:0]  prediv;
      logic [DIV_W-1:0]  cpu_div;
   } freq_req_type;

   typedef struct packed {
      logic              done;
      logic [FREQ_W-1:0] freq;
   } freq_rsp_type;

   // input clock frequency in Hz for each source code
   function automatic logic [FIN_W-1:0] fin_hz(input logic [CLK_SRC_W-1:0] src);
      logic [FIN_W-1:0] f;
      case (src)
         SRC_4MHZ:  f = 24'd4000000;
         SRC_12MHZ: f = 24'd12000000;
         SRC_32KHZ: f = 24'd32768;
         default:   f = '0;
      endcase
      return f;
   endfunction

endpackage

// ===== rtl/pccv_div.sv =====
// Bit-serial restoring divider shared by both divisions of a frequency calculation.
module pccv_div (
   input  logic                 clock,
   input  logic                 reset,
   input  pccv_pkg::div_req_type div_req,
   output pccv_pkg::div_rsp_type div_rsp
);
   import pccv_pkg::*;

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    rem_diff;
   logic                  q_bit;

   // one quotient bit per cycle, most significant first
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      rem_diff  = rem_shift - {1'b0, dsr_ff};
      q_bit     = (rem_shift >= {1'b0, dsr_ff});
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = q_bit ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], q_bit};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/pccv_freq.sv =====
// Sequencer that computes the CPU clock from M, N and C using the shared divider.
module pccv_freq (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [pccv_pkg::CLK_SRC_W-1:0]     clock_source,
   input  pccv_pkg::freq_req_type             freq_req,
   output pccv_pkg::freq_rsp_type             freq_rsp,
   output pccv_pkg::div_req_type              div_req,
   input  pccv_pkg::div_rsp_type              div_rsp
);
   import pccv_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_DIV1,
      F_WAIT1,
      F_WAIT2
   } fstate_type;

   fstate_type          state_ff, state_in;
   logic [MULT_W-1:0]   mult_ff, mult_in;
   logic [DIV_W-1:0]    prediv_ff, prediv_in;
   logic [DIV_W-1:0]    cpu_div_ff, cpu_div_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                done_ff, done_in;
   logic [FREQ_W-1:0]   freq_ff, freq_in;
   logic [DIVIDEND_W-1:0] prod_full;
   logic                fcco_ok;

   // (M+1) * fin, registered before the divider
   assign prod_full = {{MULT_P1_W{1'b0}}, fin_hz(clock_source)} *
                      {{FIN_W{1'b0}}, ({1'b0, mult_ff} + MULT_P1_W'(1))};
   assign fcco_ok   = (div_rsp.quotient >= FCCO_LO) && (div_rsp.quotient <= FCCO_HI);

   // drive the divider: 2*(M+1)*fin / (N+1) gives fcco first, then fcco / (C+1)
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = {prod_ff, 1'b0};
      div_req.divisor  = {1'b0, prediv_ff} + DIVISOR_W'(1);
      if (state_ff == F_DIV1) begin
         div_req.start = 1'b1;
      end else if (state_ff == F_WAIT1) begin
         div_req.start    = div_rsp.done && fcco_ok;
         div_req.dividend = div_rsp.quotient;
         div_req.divisor  = {1'b0, cpu_div_ff} + DIVISOR_W'(1);
      end
   end

   // advance the sequence
   always_comb begin
      state_in   = state_ff;
      mult_in    = mult_ff;
      prediv_in  = prediv_ff;
      cpu_div_in = cpu_div_ff;
      prod_in    = prod_ff;
      done_in    = 1'b0;
      freq_in    = freq_ff;
      case (state_ff)
         F_IDLE: begin
            if (freq_req.start) begin
               mult_in    = freq_req.mult;
               prediv_in  = freq_req.prediv;
               cpu_div_in = freq_req.cpu_div;
               if (clock_source == SRC_INVALID) begin
                  freq_in = '0;
                  done_in = 1'b1;
               end else begin
                  state_in = F_MUL;
               end
            end
         end
         F_MUL: begin
            prod_in  = prod_full[PROD_W-1:0];
            state_in = F_DIV1;
         end
         F_DIV1: begin
            state_in = F_WAIT1;
         end
         F_WAIT1: begin
            if (div_rsp.done) begin
               if (fcco_ok) begin
                  state_in = F_WAIT2;
               end else begin
                  freq_in  = '0;
                  done_in  = 1'b1;
                  state_in = F_IDLE;
               end
            end
         end
         F_WAIT2: begin
            if (div_rsp.done) begin
               freq_in  = div_rsp.quotient[FREQ_W-1:0];
               done_in  = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
         freq_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         freq_ff  <= freq_in;
      end
      mult_ff    <= mult_in;
      prediv_ff  <= prediv_in;
      cpu_div_ff <= cpu_div_in;
      prod_ff    <= prod_in;
   end

   assign freq_rsp.done = done_ff;
   assign freq_rsp.freq = freq_ff;

endmodule

// ===== rtl/pll_clock_config_validator_top.sv =====
// Top level of the PLL clock configuration validator: settings, command sequencer, result register.
//
//   channel | handshake       | payload                                       | dir
//   req     | req_valid/ready | req_cmd, req_field_sel                        | in
//   rsp     | rsp_valid/ready | rsp_shadow_*_out, rsp_*_freq_hz, rsp_status   | out
//   csr     | csr_valid/ready | csr_clock_source                              | in
//
// A calculation with fcco inside its window is one multiply plus two 40-step passes through
// the shared divider; with fcco outside it stops after the first pass, with source 3 at once.
// An increment, decrement, unused command or accepted apply runs one calculation before its
// result; a rejected apply runs two calculations. req_ready is high only in idle; a result
// waiting in the output register holds back the next result, not the next request. Reset
// clears state, settings, active values, status and rsp_valid, but not the result data.
module pll_clock_config_validator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pccv_pkg::CMD_W-1:0]        req_cmd,
   input  logic [pccv_pkg::SEL_W-1:0]        req_field_sel,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pccv_pkg::MULT_W-1:0]       rsp_shadow_mult_out,
   output logic [pccv_pkg::DIV_W-1:0]        rsp_shadow_prediv_out,
   output logic [pccv_pkg::DIV_W-1:0]        rsp_shadow_cpu_div_out,
   output logic [pccv_pkg::FREQ_W-1:0]       rsp_calc_freq_hz,
   output logic [pccv_pkg::FREQ_W-1:0]       rsp_active_freq_hz,
   output logic                              rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pccv_pkg::CLK_SRC_W-1:0]    csr_clock_source
);
   import pccv_pkg::*;

   typedef enum logic [2:0] {
      T_IDLE,
      T_PRE_GO,
      T_PRE_WAIT,
      T_POST_GO,
      T_POST_WAIT,
      T_OUT
   } tstate_type;

   tstate_type            state_ff, state_in;
   logic [CLK_SRC_W-1:0]  clock_source_ff, clock_source_in;
   logic [MULT_W-1:0]     shadow_mult_ff, shadow_mult_in;
   logic [DIV_W-1:0]      shadow_prediv_ff, shadow_prediv_in;
   logic [DIV_W-1:0]      shadow_cpu_div_ff, shadow_cpu_div_in;
   logic [MULT_W-1:0]     active_mult_ff, active_mult_in;
   logic [DIV_W-1:0]      active_prediv_ff, active_prediv_in;
   logic [DIV_W-1:0]      active_cpu_div_ff, active_cpu_div_in;
   logic [FREQ_W-1:0]     active_freq_ff, active_freq_in;
   logic [FREQ_W-1:0]     calc_ff, calc_in;
   logic                  status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MULT_W-1:0]     rsp_mult_ff, rsp_mult_in;
   logic [DIV_W-1:0]      rsp_prediv_ff, rsp_prediv_in;
   logic [DIV_W-1:0]      rsp_cpu_div_ff, rsp_cpu_div_in;
   logic [FREQ_W-1:0]     rsp_calc_ff, rsp_calc_in;
   logic [FREQ_W-1:0]     rsp_active_ff, rsp_active_in;
   logic                  rsp_status_ff, rsp_status_in;

   freq_req_type freq_req;
   freq_rsp_type freq_rsp;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   // frequency sequencer and its shared divider
   pccv_freq u_freq (
      .clock        (clock),
      .reset        (reset),
      .clock_source (clock_source_ff),
      .freq_req     (freq_req),
      .freq_rsp     (freq_rsp),
      .div_req      (div_req),
      .div_rsp      (div_rsp)
   );

   pccv_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // calculate on the current shadow settings
   assign freq_req.start   = (state_ff == T_PRE_GO) || (state_ff == T_POST_GO);
   assign freq_req.mult    = shadow_mult_ff;
   assign freq_req.prediv  = shadow_prediv_ff;
   assign freq_req.cpu_div = shadow_cpu_div_ff;

   // command sequencer
   always_comb begin
      state_in          = state_ff;
      clock_source_in   = clock_source_ff;
      shadow_mult_in    = shadow_mult_ff;
      shadow_prediv_in  = shadow_prediv_ff;
      shadow_cpu_div_in = shadow_cpu_div_ff;
      active_mult_in    = active_mult_ff;
      active_prediv_in  = active_prediv_ff;
      active_cpu_div_in = active_cpu_div_ff;
      active_freq_in    = active_freq_ff;
      calc_in           = calc_ff;
      status_in         = status_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_mult_in       = rsp_mult_ff;
      rsp_prediv_in     = rsp_prediv_ff;
      rsp_cpu_div_in    = rsp_cpu_div_ff;
      rsp_calc_in       = rsp_calc_ff;
      rsp_active_in     = rsp_active_ff;
      rsp_status_in     = rsp_status_ff;

      // take a configuration write
      if (csr_valid) begin
         clock_source_in = csr_clock_source;
      end

      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         T_IDLE: begin
            if (req_valid) begin
               status_in = 1'b0;
               state_in  = T_POST_GO;
               case (req_cmd)
                  CMD_DEC, CMD_INC: begin
                     case (req_field_sel)
                        SEL_MULT: begin
                           if (req_cmd == CMD_INC) begin
                              if (shadow_mult_ff != MULT_MAX)
                                 shadow_mult_in = shadow_mult_ff + MULT_W'(1);
                           end else if (shadow_mult_ff != '0) begin
                              shadow_mult_in = shadow_mult_ff - MULT_W'(1);
                           end
                        end
                        SEL_PREDIV: begin
                           if (req_cmd == CMD_INC) begin
                              if (shadow_prediv_ff != DIV_MAX)
                                 shadow_prediv_in = shadow_prediv_ff + DIV_W'(1);
                           end else if (shadow_prediv_ff != '0) begin
                              shadow_prediv_in = shadow_prediv_ff - DIV_W'(1);
                           end
                        end
                        SEL_CPU_DIV: begin
                           if (req_cmd == CMD_INC) begin
                              if (shadow_cpu_div_ff != DIV_MAX)
                                 shadow_cpu_div_in = shadow_cpu_div_ff + DIV_W'(1);
                           end else if (shadow_cpu_div_ff != '0) begin
                              shadow_cpu_div_in = shadow_cpu_div_ff - DIV_W'(1);
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
                  CMD_APPLY: begin
                     state_in = T_PRE_GO;
                  end
                  default: begin
                  end
               endcase
            end
         end
         T_PRE_GO: begin
            state_in = T_PRE_WAIT;
         end
         T_PRE_WAIT: begin
            if (freq_rsp.done) begin
               if ((freq_rsp.freq <= CCLK_LO) || (freq_rsp.freq > CCLK_HI)) begin
                  // reject: reload shadow and recalculate
                  shadow_mult_in    = active_mult_ff;
                  shadow_prediv_in  = active_prediv_ff;
                  shadow_cpu_div_in = active_cpu_div_ff;
                  status_in         = 1'b1;
                  state_in          = T_POST_GO;
               end else begin
                  // commit shadow to active
                  active_mult_in    = shadow_mult_ff;
                  active_prediv_in  = shadow_prediv_ff;
                  active_cpu_div_in = shadow_cpu_div_ff;
                  active_freq_in    = freq_rsp.freq;
                  calc_in           = freq_rsp.freq;
                  state_in          = T_OUT;
               end
            end
         end
         T_POST_GO: begin
            state_in = T_POST_WAIT;
         end
         T_POST_WAIT: begin
            if (freq_rsp.done) begin
               calc_in  = freq_rsp.freq;
               state_in = T_OUT;
            end
         end
         T_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_mult_in    = shadow_mult_ff;
               rsp_prediv_in  = shadow_prediv_ff;
               rsp_cpu_div_in = shadow_cpu_div_ff;
               rsp_calc_in    = calc_ff;
               rsp_active_in  = active_freq_ff;
               rsp_status_in  = status_ff;
               state_in       = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= T_IDLE;
         clock_source_ff   <= SRC_4MHZ;
         shadow_mult_ff    <= '0;
         shadow_prediv_ff  <= '0;
         shadow_cpu_div_ff <= '0;
         active_mult_ff    <= '0;
         active_prediv_ff  <= '0;
         active_cpu_div_ff <= '0;
         active_freq_ff    <= '0;
         status_ff         <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         clock_source_ff   <= clock_source_in;
         shadow_mult_ff    <= shadow_mult_in;
         shadow_prediv_ff  <= shadow_prediv_in;
         shadow_cpu_div_ff <= shadow_cpu_div_in;
         active_mult_ff    <= active_mult_in;
         active_prediv_ff  <= active_prediv_in;
         active_cpu_div_ff <= active_cpu_div_in;
         active_freq_ff    <= active_freq_in;
         status_ff         <= status_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      calc_ff        <= calc_in;
      rsp_mult_ff    <= rsp_mult_in;
      rsp_prediv_ff  <= rsp_prediv_in;
      rsp_cpu_div_ff <= rsp_cpu_div_in;
      rsp_calc_ff    <= rsp_calc_in;
      rsp_active_ff  <= rsp_active_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign req_ready              = (state_ff == T_IDLE);
   assign csr_ready              = 1'b1;
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_shadow_mult_out    = rsp_mult_ff;
   assign rsp_shadow_prediv_out  = rsp_prediv_ff;
   assign rsp_shadow_cpu_div_out = rsp_cpu_div_ff;
   assign rsp_calc_freq_hz       = rsp_calc_ff;
   assign rsp_active_freq_hz     = rsp_active_ff;
   assign rsp_status             = rsp_status_ff;

endmodule

// ===== rtl/pccv_checker.sv =====
// Port-level assertions for the PLL clock configuration validator, bound to the top level.
module pccv_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [pccv_pkg::FREQ_W-1:0]       rsp_calc_freq_hz,
   input logic [pccv_pkg::FREQ_W-1:0]       rsp_active_freq_hz
);
   import pccv_pkg::*;

   // a pending result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   // one transaction at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a transaction is in progress");

   // a computed clock never exceeds the fcco ceiling
   a_calc_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_calc_freq_hz <= 30'd550000000)
      else $error("calculated frequency above the fcco limit");

   // the active clock is either unset or inside the committed window
   a_active_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_active_freq_hz == '0) ||
                    ((rsp_active_freq_hz > CCLK_LO) && (rsp_active_freq_hz <= CCLK_HI)))
      else $error("active frequency outside the CPU clock window");

endmodule

bind pll_clock_config_validator_top pccv_checker u_pccv_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_calc_freq_hz   (rsp_calc_freq_hz),
   .rsp_active_freq_hz (rsp_active_freq_hz)
);

// ===== tb/tb_pll_clock_config_validator_top.sv =====
// Self-checking testbench for the PLL clock configuration validator top level.
module tb_pll_clock_config_validator_top;
   import pccv_pkg::*;

   // command and selector codes the block leaves unused
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [SEL_W-1:0] SEL_UNUSED = 2'd3;

   // saturation limits and frequency windows
   localparam int unsigned MULT_TOP = 32767;
   localparam int unsigned DIV_TOP  = 255;
   localparam logic [63:0] CCO_FLOOR_HZ = 64'd275000000;
   localparam logic [63:0] CCO_CEIL_HZ  = 64'd550000000;
   localparam logic [FREQ_W-1:0] CPU_FLOOR_HZ = 30'd10000000;
   localparam logic [FREQ_W-1:0] CPU_CEIL_HZ  = 30'd100000000;

   typedef struct packed {
      logic [MULT_W-1:0] mult;
      logic [DIV_W-1:0]  prediv;
      logic [DIV_W-1:0]  cpu_div;
      logic [FREQ_W-1:0] calc_hz;
      logic [FREQ_W-1:0] active_hz;
      logic              status;
   } pll_report_type;

   // DUT signals
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_cmd = CMD_DEC;
   logic [SEL_W-1:0]     req_field_sel = SEL_MULT;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [MULT_W-1:0]    rsp_shadow_mult_out;
   logic [DIV_W-1:0]     rsp_shadow_prediv_out;
   logic [DIV_W-1:0]     rsp_shadow_cpu_div_out;
   logic [FREQ_W-1:0]    rsp_calc_freq_hz;
   logic [FREQ_W-1:0]    rsp_active_freq_hz;
   logic                 rsp_status;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CLK_SRC_W-1:0] csr_clock_source = SRC_4MHZ;

   // mirror of the block's settings
   logic [CLK_SRC_W-1:0] clk_src = SRC_4MHZ;
   logic [MULT_W-1:0]    sh_mult = '0;
   logic [DIV_W-1:0]     sh_prediv = '0;
   logic [DIV_W-1:0]     sh_cpu_div = '0;
   logic [MULT_W-1:0]    act_mult = '0;
   logic [DIV_W-1:0]     act_prediv = '0;
   logic [DIV_W-1:0]     act_cpu_div = '0;
   logic [FREQ_W-1:0]    act_freq = '0;

   pll_report_type pll_reports_due[$];
   int unsigned commands_sent = 0;
   int unsigned applies_taken = 0;
   int unsigned applies_refused = 0;
   int unsigned error_count = 0;
   int unsigned stall_left = 0;
   bit          gaps_on = 1'b1;

   pll_clock_config_validator_top uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_cmd                (req_cmd),
      .req_field_sel          (req_field_sel),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_shadow_mult_out    (rsp_shadow_mult_out),
      .rsp_shadow_prediv_out  (rsp_shadow_prediv_out),
      .rsp_shadow_cpu_div_out (rsp_shadow_cpu_div_out),
      .rsp_calc_freq_hz       (rsp_calc_freq_hz),
      .rsp_active_freq_hz     (rsp_active_freq_hz),
      .rsp_status             (rsp_status),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_clock_source       (csr_clock_source)
   );

   always #5 clock = ~clock;

   // CPU clock in Hz for one set of settings, zero when the CCO is out of its window
   function automatic logic [FREQ_W-1:0] cclk_for(input logic [CLK_SRC_W-1:0] src,
                                                 input logic [MULT_W-1:0] m,
                                                 input logic [DIV_W-1:0] n,
                                                 input logic [DIV_W-1:0] c);
      logic [63:0] fin;
      logic [63:0] fcco;
      case (src)
         SRC_4MHZ:  fin = 64'd4000000;
         SRC_12MHZ: fin = 64'd12000000;
         SRC_32KHZ: fin = 64'd32768;
         default:   fin = 64'd0;
      endcase
      fcco = (64'd2 * (64'(m) + 64'd1) * fin) / (64'(n) + 64'd1);
      if (fcco < CCO_FLOOR_HZ || fcco > CCO_CEIL_HZ)
         return '0;
      return FREQ_W'(fcco / (64'(c) + 64'd1));
   endfunction

   // step a setting by one, holding at zero and at its top
   function automatic int unsigned nudge(input int unsigned v, input int unsigned top,
                                         input bit up);
      if (up)
         return (v < top) ? v + 1 : v;
      return (v != 0) ? v - 1 : v;
   endfunction

   // advance the settings mirror by one command and return the report it produces
   function automatic pll_report_type run_pll_command(input logic [CMD_W-1:0] cmd,
                                                      input logic [SEL_W-1:0] sel);
      pll_report_type rpt;
      logic [FREQ_W-1:0] f;
      rpt.status = 1'b0;
      if (cmd == CMD_DEC || cmd == CMD_INC) begin
         case (sel)
            SEL_MULT:    sh_mult    = MULT_W'(nudge(32'(sh_mult), MULT_TOP, cmd == CMD_INC));
            SEL_PREDIV:  sh_prediv  = DIV_W'(nudge(32'(sh_prediv), DIV_TOP, cmd == CMD_INC));
            SEL_CPU_DIV: sh_cpu_div = DIV_W'(nudge(32'(sh_cpu_div), DIV_TOP, cmd == CMD_INC));
            default: ;
         endcase
      end else if (cmd == CMD_APPLY) begin
         f = cclk_for(clk_src, sh_mult, sh_prediv, sh_cpu_div);
         if (f <= CPU_FLOOR_HZ || f > CPU_CEIL_HZ) begin
            // refused: fall back to the active settings
            sh_mult    = act_mult;
            sh_prediv  = act_prediv;
            sh_cpu_div = act_cpu_div;
            rpt.status = 1'b1;
            applies_refused++;
         end else begin
            act_mult    = sh_mult;
            act_prediv  = sh_prediv;
            act_cpu_div = sh_cpu_div;
            act_freq    = f;
            applies_taken++;
         end
      end
      rpt.mult      = sh_mult;
      rpt.prediv    = sh_prediv;
      rpt.cpu_div   = sh_cpu_div;
      rpt.calc_hz   = cclk_for(clk_src, sh_mult, sh_prediv, sh_cpu_div);
      rpt.active_hz = act_freq;
      return rpt;
   endfunction

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         error_count++;
      end
   endtask

   // send one command transaction and record its report once it is taken
   task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [SEL_W-1:0] sel);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_field_sel <= sel;
      do @(posedge clock); while (!req_ready);
      pll_reports_due.push_back(run_pll_command(cmd, sel));
      commands_sent++;
   endtask

   // hold off new commands until every report has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pll_reports_due.size() != 0);
   endtask

   task automatic set_clock_source(input logic [CLK_SRC_W-1:0] src);
      drain_results();
      csr_valid        <= 1'b1;
      csr_clock_source <= src;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      clk_src = src;
   endtask

   task automatic issue_noise();
      issue_command(CMD_W'($urandom_range(0, 3)), SEL_W'($urandom_range(0, 3)));
   endtask

   // walk the shadow settings toward a target near the valid window, then apply
   task automatic walk_and_apply();
      logic [DIV_W-1:0]  n_goal;
      logic [DIV_W-1:0]  c_goal;
      logic [MULT_W-1:0] m_goal;
      logic [SEL_W-1:0]  sel;
      int                m_int;
      int unsigned       span;
      int unsigned       cur;
      int unsigned       goal;
      case (clk_src)
         SRC_12MHZ: begin
            n_goal = DIV_W'($urandom_range(0, 2));
            span   = 32'(n_goal) + 1;
            m_int  = span * $urandom_range(11, 23) + $urandom_range(0, 4) - 3;
         end
         SRC_4MHZ: begin
            n_goal = DIV_W'($urandom_range(0, 1));
            span   = 32'(n_goal) + 1;
            m_int  = span * $urandom_range(34, 69) + $urandom_range(0, 4) - 3;
         end
         default: begin
            n_goal = DIV_W'($urandom_range(0, 3));
            m_int  = int'(sh_mult) + $urandom_range(0, 20) - 10;
         end
      endcase
      if (m_int < 0)
         m_int = 0;
      m_goal = MULT_W'(m_int);
      c_goal = DIV_W'($urandom_range(1, 56));
      while (sh_mult != m_goal || sh_prediv != n_goal || sh_cpu_div != c_goal) begin
         // cut the walk short now and then
         if ($urandom_range(0, 199) == 0)
            break;
         if ($urandom_range(0, 11) == 0) begin
            issue_noise();
            continue;
         end
         case ($urandom_range(0, 2))
            0:       sel = SEL_MULT;
            1:       sel = SEL_PREDIV;
            default: sel = SEL_CPU_DIV;
         endcase
         case (sel)
            SEL_MULT:   begin cur = 32'(sh_mult);    goal = 32'(m_goal); end
            SEL_PREDIV: begin cur = 32'(sh_prediv);  goal = 32'(n_goal); end
            default:    begin cur = 32'(sh_cpu_div); goal = 32'(c_goal); end
         endcase
         if (cur != goal)
            issue_command(cur < goal ? CMD_INC : CMD_DEC, sel);
      end
      issue_command(CMD_APPLY, SEL_W'($urandom_range(0, 3)));
   endtask

   // decrements at zero, unused codes, apply from the reset settings
   task automatic test_idle_and_unused_codes();
      set_clock_source(SRC_4MHZ);
      issue_command(CMD_DEC, SEL_MULT);
      issue_command(CMD_DEC, SEL_PREDIV);
      issue_command(CMD_DEC, SEL_CPU_DIV);
      issue_command(CMD_UNUSED, SEL_MULT);
      issue_command(CMD_UNUSED, SEL_UNUSED);
      issue_command(CMD_INC, SEL_UNUSED);
      issue_command(CMD_DEC, SEL_UNUSED);
      // CCO far below its window: refused
      issue_command(CMD_APPLY, SEL_MULT);
   endtask

   // reach 288 MHz CCO from 12 MHz and commit a 96 MHz CPU clock
   task automatic test_first_lock();
      set_clock_source(SRC_12MHZ);
      repeat (11) issue_command(CMD_INC, SEL_MULT);
      repeat (2) issue_command(CMD_INC, SEL_CPU_DIV);
      issue_command(CMD_APPLY, SEL_UNUSED);
   endtask

   // invalid source and 32768 Hz source both refuse the apply
   task automatic test_bad_sources();
      set_clock_source(SRC_INVALID);
      issue_command(CMD_APPLY, SEL_CPU_DIV);
      set_clock_source(SRC_32KHZ);
      issue_command(CMD_INC, SEL_PREDIV);
      issue_command(CMD_APPLY, SEL_PREDIV);
   endtask

   // drive both 8-bit dividers into their top limit
   task automatic test_divider_saturation();
      set_clock_source(SRC_INVALID);
      repeat (257) issue_command(CMD_INC, SEL_PREDIV);
      repeat (257) issue_command(CMD_INC, SEL_CPU_DIV);
      issue_command(CMD_DEC, SEL_PREDIV);
      issue_command(CMD_INC, SEL_MULT);
      issue_command(CMD_APPLY, SEL_MULT);
   endtask

   // phases of random clock source, each a mix of walks, applies and noise
   task automatic test_random_walks(input int unsigned goal);
      logic [CLK_SRC_W-1:0] src;
      int unsigned          phase_end;
      while (commands_sent < goal) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: src = SRC_4MHZ;
            4, 5, 6, 7: src = SRC_12MHZ;
            8:          src = SRC_32KHZ;
            default:    src = SRC_INVALID;
         endcase
         set_clock_source(src);
         phase_end = commands_sent + ((src == SRC_4MHZ || src == SRC_12MHZ) ?
                                      $urandom_range(60, 200) : $urandom_range(10, 30));
         while (commands_sent < phase_end && commands_sent < goal) begin
            if ($urandom_range(0, 6) == 0)
               repeat ($urandom_range(1, 6)) issue_noise();
            else
               walk_and_apply();
         end
      end
   endtask

   // check each report transaction and drive the response-side stalls
   always @(posedge clock) begin : rsp_side
      pll_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pll_reports_due.size() == 0) begin
            $display("%0t: report with none outstanding, expected nothing, actual mult %0d",
                     $time, rsp_shadow_mult_out);
            error_count++;
         end else begin
            want = pll_reports_due.pop_front();
            check_field("shadow_mult_out", 32'(want.mult), 32'(rsp_shadow_mult_out));
            check_field("shadow_prediv_out", 32'(want.prediv), 32'(rsp_shadow_prediv_out));
            check_field("shadow_cpu_div_out", 32'(want.cpu_div),
                        32'(rsp_shadow_cpu_div_out));
            check_field("calc_freq_hz", 32'(want.calc_hz), 32'(rsp_calc_freq_hz));
            check_field("active_freq_hz", 32'(want.active_hz), 32'(rsp_active_freq_hz));
            check_field("status", 32'(want.status), 32'(rsp_status));
         end
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_idle_and_unused_codes();
      test_first_lock();
      test_bad_sources();
      test_divider_saturation();
      test_random_walks(1400);
      // final stretch at full rate on both sides
      gaps_on = 1'b0;
      test_random_walks(1550);
      drain_results();
      repeat (200) @(posedge clock);
      $display("%0d commands checked: %0d applies committed, %0d refused", commands_sent,
               applies_taken, applies_refused);
      $display("all four clock sources, unused codes, zero and divider top saturation hit");
      if (error_count == 0)
         $display("tb_pll_clock_config_validator_top: done, clean");
      else
         $display("tb_pll_clock_config_validator_top: done, errors");
      $finish;
   end

   // watchdog
   initial begin
      #20000000;
      $display("%0t: timeout with %0d reports outstanding", $time, pll_reports_due.size());
      $display("tb_pll_clock_config_validator_top: done, errors");
      $finish;
   end

endmodule

// ===== pll_clock_config_validator_top.f =====
rtl/pccv_pkg.sv
rtl/pccv_div.sv
rtl/pccv_freq.sv
rtl/pll_clock_config_validator_top.sv
rtl/pccv_checker.sv
tb/tb_pll_clock_config_validator_top.sv
